// File: hw/rtl/ps2_mouse_packet_tracker_defines.svh
// Assertion macros used by the checker of the packet tracker.
`ifndef PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH

// Check an implication on every rising clock edge outside reset.
`define PS2MPT_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a next-cycle implication on every rising clock edge outside reset.
`define PS2MPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/ps2mpt_pkg.sv
package ps2mpt_pkg;

   localparam int RX_BYTE_BITS   = 8;
   localparam int BOUND_BITS     = 13;
   localparam int CSR_INDEX_BITS = 4;
   localparam int MOVE_X_BITS    = 9;
   localparam int MOVE_Y_BITS    = 10;
   localparam int BTN_BITS       = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_WIDTH_BOUND  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_HEIGHT_BOUND = CSR_INDEX_BITS'(1);

   localparam logic [BOUND_BITS-1:0] WIDTH_BOUND_RESET  = BOUND_BITS'(320);
   localparam logic [BOUND_BITS-1:0] HEIGHT_BOUND_RESET = BOUND_BITS'(200);

   localparam int CUR_X_RESET = 160;
   localparam int CUR_Y_RESET = 100;

   localparam int HEAD_ALWAYS_ONE_BIT = 3;
   localparam int HEAD_X_SIGN_BIT     = 4;
   localparam int HEAD_Y_SIGN_BIT     = 5;

   typedef struct packed {
      logic                    valid;
      logic [RX_BYTE_BITS-1:0] rx_byte;
      logic                    aux_flag;
   } byte_beat_type;

   typedef struct packed {
      logic [BOUND_BITS-1:0] width_bound;
      logic [BOUND_BITS-1:0] height_bound;
   } bounds_type;

endpackage

// File: hw/rtl/ps2mpt_csr.sv
module ps2mpt_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ps2mpt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ps2mpt_pkg::BOUND_BITS-1:0]     csr_data,
   output ps2mpt_pkg::bounds_type                bounds
);
   import ps2mpt_pkg::*;

   logic [BOUND_BITS-1:0] width_ff;
   logic [BOUND_BITS-1:0] height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_BOUND_RESET;
         height_ff <= HEIGHT_BOUND_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_WIDTH_BOUND:  width_ff  <= csr_data;
            REG_HEIGHT_BOUND: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign bounds.width_bound  = width_ff;
   assign bounds.height_bound = height_ff;

endmodule

// File: hw/rtl/ps2mpt_input_stage.sv
module ps2mpt_input_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ps2mpt_pkg::RX_BYTE_BITS-1:0] req_tdata,
   input  logic                                req_tuser,
   input  logic                                take,
   output ps2mpt_pkg::byte_beat_type           beat
);
   import ps2mpt_pkg::*;

   logic                    valid_ff;
   logic [RX_BYTE_BITS-1:0] byte_ff;
   logic                    aux_ff;

   assign req_tready = !valid_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         byte_ff <= req_tdata;
         aux_ff  <= req_tuser;
      end
   end

   assign beat.valid    = valid_ff;
   assign beat.rx_byte  = byte_ff;
   assign beat.aux_flag = aux_ff;

endmodule

// File: hw/rtl/ps2mpt_packet_core.sv
module ps2mpt_packet_core #(
   parameter int COORD_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ps2mpt_pkg::byte_beat_type              beat,
   input  ps2mpt_pkg::bounds_type                 bounds,
   output logic                                   take,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [COORD_BITS-1:0]                  pos_x,
   output logic [COORD_BITS-1:0]                  pos_y,
   output logic [ps2mpt_pkg::MOVE_X_BITS-1:0]     move_x,
   output logic [ps2mpt_pkg::MOVE_Y_BITS-1:0]     move_y,
   output logic [ps2mpt_pkg::BTN_BITS-1:0]        buttons
);
   import ps2mpt_pkg::*;

   localparam int SUM_BITS = COORD_BITS + 2;
   localparam int CMP_BITS = (COORD_BITS + 1 > BOUND_BITS) ? COORD_BITS + 1 : BOUND_BITS;
   localparam logic [CMP_BITS-1:0]   COORD_LIMIT = CMP_BITS'(1) << COORD_BITS;
   localparam logic [COORD_BITS-1:0] X_RESET     = COORD_BITS'(CUR_X_RESET);
   localparam logic [COORD_BITS-1:0] Y_RESET     = COORD_BITS'(CUR_Y_RESET);

   typedef enum logic [1:0] {
      PH_HEAD,
      PH_DX,
      PH_DY
   } phase_type;

   function automatic logic [COORD_BITS-1:0] coord_top(input logic [BOUND_BITS-1:0] bound);
      logic [CMP_BITS-1:0] bext;
      bext = CMP_BITS'(bound);
      if (bound == '0) begin
         coord_top = '0;
      end else if (bext > COORD_LIMIT) begin
         coord_top = '1;
      end else begin
         coord_top = COORD_BITS'(bext - CMP_BITS'(1));
      end
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp(input logic [SUM_BITS-1:0] sum,
                                                   input logic [COORD_BITS-1:0] top);
      if (sum[SUM_BITS-1]) begin
         clamp = '0;
      end else if (sum[SUM_BITS-2:0] > {1'b0, top}) begin
         clamp = top;
      end else begin
         clamp = sum[COORD_BITS-1:0];
      end
   endfunction

   phase_type               phase_ff;
   logic [RX_BYTE_BITS-1:0] head_ff;
   logic [RX_BYTE_BITS-1:0] dx_ff;
   logic [COORD_BITS-1:0]   cur_x_ff;
   logic [COORD_BITS-1:0]   cur_y_ff;
   logic                    rsp_valid_ff;
   logic [COORD_BITS-1:0]   pos_x_ff;
   logic [COORD_BITS-1:0]   pos_y_ff;
   logic [MOVE_X_BITS-1:0]  move_x_ff;
   logic [MOVE_Y_BITS-1:0]  move_y_ff;
   logic [BTN_BITS-1:0]     buttons_ff;

   logic                    last_byte;
   logic                    emit;
   logic                    rsp_valid_in;
   logic [MOVE_X_BITS-1:0]  dx;
   logic [MOVE_X_BITS-1:0]  dy;
   logic [SUM_BITS-1:0]     sum_x;
   logic [SUM_BITS-1:0]     sum_y;
   logic [COORD_BITS-1:0]   cur_x_in;
   logic [COORD_BITS-1:0]   cur_y_in;
   logic [MOVE_Y_BITS-1:0]  move_y_in;

   always_comb begin
      last_byte    = (phase_ff != PH_HEAD) && (phase_ff != PH_DX);
      emit         = beat.aux_flag && last_byte && head_ff[HEAD_ALWAYS_ONE_BIT];
      take         = beat.valid && (!(rsp_valid_ff && !rsp_ready) || !emit);
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (take && emit);
      dx           = {head_ff[HEAD_X_SIGN_BIT], dx_ff};
      dy           = {head_ff[HEAD_Y_SIGN_BIT], beat.rx_byte};
      sum_x        = {2'b00, cur_x_ff} + {{(SUM_BITS - MOVE_X_BITS){dx[MOVE_X_BITS-1]}}, dx};
      sum_y        = {2'b00, cur_y_ff} - {{(SUM_BITS - MOVE_X_BITS){dy[MOVE_X_BITS-1]}}, dy};
      cur_x_in     = clamp(sum_x, coord_top(bounds.width_bound));
      cur_y_in     = clamp(sum_y, coord_top(bounds.height_bound));
      move_y_in    = MOVE_Y_BITS'(0) - {dy[MOVE_X_BITS-1], dy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEAD;
         head_ff      <= '0;
         dx_ff        <= '0;
         cur_x_ff     <= X_RESET;
         cur_y_ff     <= Y_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take && beat.aux_flag) begin
            case (phase_ff)
               PH_HEAD: begin
                  head_ff  <= beat.rx_byte;
                  phase_ff <= PH_DX;
               end
               PH_DX: begin
                  dx_ff    <= beat.rx_byte;
                  phase_ff <= PH_DY;
               end
               default: begin
                  phase_ff <= PH_HEAD;
                  if (emit) begin
                     cur_x_ff     <= cur_x_in;
                     cur_y_ff     <= cur_y_in;
                     pos_x_ff     <= cur_x_in;
                     pos_y_ff     <= cur_y_in;
                     move_x_ff    <= dx;
                     move_y_ff    <= move_y_in;
                     buttons_ff   <= head_ff[BTN_BITS-1:0];
                  end
               end
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign pos_x     = pos_x_ff;
   assign pos_y     = pos_y_ff;
   assign move_x    = move_x_ff;
   assign move_y    = move_y_ff;
   assign buttons   = buttons_ff;

endmodule

// File: hw/rtl/ps2_mouse_packet_tracker.sv
// Tracks a cursor from PS/2 controller bytes, one byte per cycle with no bubbles while no byte
// is held. A byte is registered on entry and decoded from there; a result is registered as the
// third byte of its packet leaves. Bytes with tuser low are dropped; a packet whose head byte
// lacks bit 3 gives no result. The entry register keeps taking bytes while a result waits; only
// a byte that completes a packet with a result holds there until the result register is free.
module ps2_mouse_packet_tracker #(
   parameter int COORD_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // rx_byte
   input  logic                                  req_tuser,  // aux_flag
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // pos_x, pos_y, move_x, move_y, btn_left, btn_right, btn_middle, zero pad
   output logic [((2*COORD_BITS+22+7)/8)*8-1:0]  rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ps2mpt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ps2mpt_pkg::BOUND_BITS-1:0]     csr_data
);
   import ps2mpt_pkg::*;

   localparam int DATA_BITS = 2 * COORD_BITS + MOVE_X_BITS + MOVE_Y_BITS + BTN_BITS;
   localparam int TDATA_BITS = ((DATA_BITS + 7) / 8) * 8;

   byte_beat_type          beat;
   bounds_type             bounds;
   logic                   take;
   logic [COORD_BITS-1:0]  pos_x;
   logic [COORD_BITS-1:0]  pos_y;
   logic [MOVE_X_BITS-1:0] move_x;
   logic [MOVE_Y_BITS-1:0] move_y;
   logic [BTN_BITS-1:0]    buttons;

   ps2mpt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .bounds    (bounds)
   );

   ps2mpt_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .beat       (beat)
   );

   ps2mpt_packet_core #(
      .COORD_BITS (COORD_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .beat      (beat),
      .bounds    (bounds),
      .take      (take),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .pos_x     (pos_x),
      .pos_y     (pos_y),
      .move_x    (move_x),
      .move_y    (move_y),
      .buttons   (buttons)
   );

   assign rsp_tdata = TDATA_BITS'({buttons, move_y, move_x, pos_y, pos_x});

endmodule

// File: hw/rtl/ps2mpt_checker.sv
`include "ps2_mouse_packet_tracker_defines.svh"

module ps2mpt_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic                                  req_tuser,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [((2*COORD_BITS+22+7)/8)*8-1:0]  rsp_tdata
);

   logic req_beat;
   logic rsp_stall;

   assign req_beat  = req_tvalid && req_tready && req_tuser;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   `PS2MPT_ASSERT_NEXT(a_rsp_valid_holds, rsp_stall, rsp_tvalid, "result dropped while stalled")
   `PS2MPT_ASSERT_NEXT(a_rsp_data_holds, rsp_stall, $stable(rsp_tdata), "result data changed")
   `PS2MPT_ASSERT(a_rsp_follows_mouse_byte, $rose(rsp_tvalid), $past(req_beat, 2), "result without a mouse byte")
   `PS2MPT_ASSERT(a_idle_after_reset, $fell(reset), !rsp_tvalid, "result present right after reset")

endmodule

bind ps2_mouse_packet_tracker ps2mpt_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);
